// File: design/pidl_pkg.sv
// shared types and constants for the positional insert/delete list
package pidl_pkg;

   localparam int DEPTH    = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int WORD_W   = 32;
   localparam int CAP_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
   localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_POS   = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                  kind;
      logic [POS_W-1:0]          position;
      logic signed [WORD_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [WORD_W-1:0]  word;
      logic [COUNT_W-1:0]        count;
      logic                      full_res;
      logic                      empty_res;
   } rsp_type;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic [IDX_W-1:0]  sel;
   } cell_cmd_type;

endpackage

// File: design/pidl_cell.sv
// one list cell: holds a word and shifts with its neighbors on insert or delete
module pidl_cell (
   input  logic                          clock,
   input  pidl_pkg::cell_cmd_type        cmd,
   input  logic [pidl_pkg::IDX_W-1:0]    my_idx,
   input  logic [pidl_pkg::IDX_W-1:0]    rd_idx,
   input  logic [pidl_pkg::WORD_W-1:0]   value,
   input  logic [pidl_pkg::WORD_W-1:0]   left_word,
   input  logic [pidl_pkg::WORD_W-1:0]   right_word,
   output logic [pidl_pkg::WORD_W-1:0]   word,
   output logic [pidl_pkg::WORD_W-1:0]   rd_word
);
   import pidl_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (my_idx > cmd.sel) begin
            word_in = left_word;
         end else if (my_idx == cmd.sel) begin
            word_in = value;
         end
      end else if (cmd.del) begin
         if (my_idx >= cmd.sel) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = (my_idx == rd_idx) ? word_ff : '0;

endmodule

// File: design/positional_insert_delete_list.sv
// top level: control, configuration port, result register and the row of list cells
//
// Ordered list of signed 32-bit words held in a row of DEPTH cells. Each item
// (insert, delete or read at a one-based position) takes effect on acceptance:
// all cells shift up or down together in that cycle and the result is written
// into the output register on acceptance. A new item is accepted every cycle
// as long as the result register is empty or being taken in the same cycle;
// req_stall is high only while a finished result waits under rsp_stall.
// The capacity register (byte address 0) may be written only while idle;
// zero acts as one and values above DEPTH act as DEPTH. No clearing pass is
// needed after reset.
module positional_insert_delete_list (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pidl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pidl_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pidl_pkg::PADDR_W-1:0]     csr_paddr,
   input  logic [pidl_pkg::PDATA_W-1:0]     csr_pwdata,
   output logic [pidl_pkg::PDATA_W-1:0]     csr_prdata,
   output logic                             csr_pready
);
   import pidl_pkg::*;

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  cap_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              accept;
   logic              csr_write;
   logic              csr_hit;
   cell_cmd_type      cmd;
   logic [IDX_W-1:0]  rd_idx;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] cell_word [DEPTH];
   logic [WORD_W-1:0] cell_rd   [DEPTH];

   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  pos_m1;
   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W-1:0]  cap_w;
   logic [CMP_W-1:0]  cnt_next;
   logic              pos_in_list;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[PADDR_W-1:2] == REG_CAPACITY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? PDATA_W'(cap_ff) : '0;
   assign cap_in     = (csr_write && csr_hit) ? csr_pwdata[CAP_W-1:0] : cap_ff;

   // handshake
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // effective capacity and position checks
   always_comb begin
      cap_w = CMP_W'(cap_ff);
      if (cap_w == '0) begin
         cap_w = CMP_W'(1);
      end else if (cap_w > CMP_W'(DEPTH)) begin
         cap_w = CMP_W'(DEPTH);
      end
   end

   assign pos_w       = CMP_W'(req_data.position);
   assign pos_m1      = pos_w - CMP_W'(1);
   assign cnt_w       = CMP_W'(cnt_ff);
   assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
   assign rd_idx      = pos_m1[IDX_W-1:0];

   // read path across the row
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   always_comb begin
      cmd              = '0;
      cnt_next         = cnt_w;
      rsp_data_in      = rsp_data_ff;
      rsp_data_in.word = '0;
      rsp_data_in.status = STATUS_DONE;
      case (req_data.kind)
         KIND_INSERT: begin
            if (cnt_w >= cap_w) begin
               rsp_data_in.status = STATUS_FULL;
            end else if ((pos_w > cnt_w) && (pos_w <= cap_w)) begin
               cmd.ins  = accept;
               cmd.sel  = cnt_w[IDX_W-1:0];
               cnt_next = cnt_w + CMP_W'(1);
            end else if (pos_in_list) begin
               cmd.ins  = accept;
               cmd.sel  = pos_m1[IDX_W-1:0];
               cnt_next = cnt_w + CMP_W'(1);
            end else begin
               rsp_data_in.status = STATUS_BAD_POS;
            end
         end
         KIND_DELETE: begin
            if (cnt_w == '0) begin
               rsp_data_in.status = STATUS_EMPTY;
            end else if (pos_in_list) begin
               cmd.del          = accept;
               cmd.sel          = pos_m1[IDX_W-1:0];
               cnt_next         = cnt_w - CMP_W'(1);
               rsp_data_in.word = rd_word;
            end else begin
               rsp_data_in.status = STATUS_BAD_POS;
            end
         end
         KIND_READ: begin
            if (pos_in_list) begin
               rsp_data_in.word = rd_word;
            end else begin
               rsp_data_in.status = STATUS_BAD_POS;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.count     = COUNT_W'(cnt_next);
      rsp_data_in.full_res  = (cnt_next >= cap_w);
      rsp_data_in.empty_res = (cnt_next == '0);
      cnt_in = accept ? CNT_W'(cnt_next) : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // row of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = req_data.value;
      end else begin : g_mid_l
         assign left_word = cell_word[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_word[g+1];
      end

      pidl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .my_idx     (IDX_W'(g)),
         .rd_idx     (rd_idx),
         .value      (req_data.value),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[g]),
         .rd_word    (cell_rd[g])
      );
   end

   // checks
   a_reset_count: assert property (@(posedge clock) reset |=> (cnt_ff == '0))
      else $error("count not cleared by reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(cnt_ff) <= CMP_W'(DEPTH)))
      else $error("count beyond depth");

   a_count_needs_item: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |-> $past(accept))
      else $error("count changed without an item");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.count == COUNT_W'(cnt_ff)))
      else $error("result count differs from list count");

endmodule

// File: tb/sv/positional_insert_delete_list_test.sv
// self-checking testbench for the positional insert/delete list
module positional_insert_delete_list_test;
   import pidl_pkg::*;

   localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
   localparam int LONG_HOLD_AT     = 350;
   localparam int LONG_HOLD_CYCLES = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]  csr_paddr = '0;
   logic [PDATA_W-1:0]  csr_pwdata = '0;
   logic [PDATA_W-1:0]  csr_prdata;
   logic                csr_pready;

   positional_insert_delete_list DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // list shadow
   logic signed [WORD_W-1:0]  list_words [0:DEPTH-1];
   int                        list_count = 0;
   logic [CAP_W-1:0]          list_capacity = CAP_RESET;

   req_type  pending_ops [$];
   rsp_type  expected_rsps [$];
   int       gen_count = 0;
   int       error_count = 0;
   int       results_seen = 0;
   int       req_wait = 0;
   int       req_burst = 0;
   int       rsp_wait = 0;
   int       rsp_burst = 0;

   function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0) return 1;
      if (cap > DEPTH) return DEPTH;
      return int'(cap);
   endfunction

   function automatic rsp_type predict_list_op(input req_type op);
      rsp_type res;
      int      cap;
      int      pos;
      int      i;
      cap = effective_capacity(list_capacity);
      pos = int'(op.position);
      res.status = STATUS_DONE;
      res.word = '0;
      case (op.kind)
         KIND_INSERT: begin
            if (list_count >= cap) begin
               res.status = STATUS_FULL;
            end else if (pos > list_count && pos <= cap) begin
               list_words[list_count] = op.value;
               list_count++;
            end else if (pos >= 1 && pos <= list_count) begin
               for (i = list_count; i > pos - 1; i--) list_words[i] = list_words[i-1];
               list_words[pos-1] = op.value;
               list_count++;
            end else begin
               res.status = STATUS_BAD_POS;
            end
         end
         KIND_DELETE: begin
            if (list_count == 0) begin
               res.status = STATUS_EMPTY;
            end else if (pos >= 1 && pos <= list_count) begin
               res.word = list_words[pos-1];
               for (i = pos; i < list_count; i++) list_words[i-1] = list_words[i];
               list_count--;
            end else begin
               res.status = STATUS_BAD_POS;
            end
         end
         KIND_READ: begin
            if (pos >= 1 && pos <= list_count) res.word = list_words[pos-1];
            else res.status = STATUS_BAD_POS;
         end
         default: begin
         end
      endcase
      res.count = COUNT_W'(list_count);
      res.full_res = (list_count >= cap);
      res.empty_res = (list_count == 0);
      return res;
   endfunction

   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
      return $urandom_range(0, 5);
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         $error("unexpected item: status %0d word %0d count %0d", got.status, got.word,
                got.count);
         error_count++;
      end else begin
         want = expected_rsps.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.word !== want.word) begin
            $error("word: expected %0d, got %0d", want.word, got.word);
            error_count++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            error_count++;
         end
         if (got.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
            error_count++;
         end
         if (got.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
            error_count++;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else if (req_valid && !req_stall) begin
         expected_rsps.push_back(predict_list_op(req_data));
         req_wait = draw_wait(req_burst);
         if (req_wait == 0 && pending_ops.size() > 0) begin
            req_data <= pending_ops.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (pending_ops.size() > 0) begin
            req_data <= pending_ops.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
            results_seen++;
            if (results_seen == LONG_HOLD_AT) rsp_wait = LONG_HOLD_CYCLES;
            else rsp_wait = draw_wait(rsp_burst);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait > 0);
      end
   end

   task automatic push_op(input kind_type k, input int pos, input logic signed [WORD_W-1:0] v);
      req_type op;
      int      cap;
      cap = effective_capacity(list_capacity);
      op.kind = k;
      op.position = POS_W'(pos);
      op.value = v;
      if (k == KIND_INSERT && gen_count < cap && pos >= 1 && pos <= cap) gen_count++;
      else if (k == KIND_DELETE && pos >= 1 && pos <= gen_count) gen_count--;
      pending_ops.push_back(op);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAPACITY_ADDR;
      csr_pwdata <= PDATA_W'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      list_capacity = cap;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_ops.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic queue_mixed_ops(input int n, input int ins_pct, input int del_pct);
      kind_type                  k;
      int                        pos;
      int                        r;
      int                        cap;
      logic signed [WORD_W-1:0]  v;
      repeat (n) begin
         cap = effective_capacity(list_capacity);
         r = $urandom_range(0, 99);
         if (r < ins_pct) k = KIND_INSERT;
         else if (r < ins_pct + del_pct) k = KIND_DELETE;
         else if (r < 97) k = KIND_READ;
         else k = KIND_NOP;
         r = $urandom_range(0, 99);
         if (r < 75) begin
            if (k == KIND_INSERT) pos = $urandom_range(1, gen_count + 1);
            else pos = $urandom_range(1, (gen_count > 0) ? gen_count : 1);
         end else if (r < 90) begin
            pos = $urandom_range(0, cap + 2);
         end else begin
            pos = $urandom_range(0, 255);
         end
         case ($urandom_range(0, 9))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = '0;
            3: v = -1;
            default: v = $urandom;
         endcase
         push_op(k, pos, v);
      end
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int ins_pct,
                            input int del_pct);
      write_capacity(cap);
      queue_mixed_ops(n, ins_pct, del_pct);
      wait_until_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity, empty list and position edges
      push_op(KIND_READ, 1, 32'sd5);
      push_op(KIND_DELETE, 1, 32'sd0);
      push_op(KIND_INSERT, 0, 32'sd1);
      push_op(KIND_INSERT, 65, 32'sd2);
      push_op(KIND_INSERT, 1, 32'sh7fffffff);
      push_op(KIND_INSERT, 1, 32'sh80000000);
      push_op(KIND_INSERT, 64, -32'sd1);
      push_op(KIND_INSERT, 2, 32'sd0);
      push_op(KIND_READ, 1, 32'sd0);
      push_op(KIND_READ, 4, 32'sd0);
      push_op(KIND_READ, 5, 32'sd0);
      push_op(KIND_READ, 0, 32'sd0);
      push_op(KIND_DELETE, 0, 32'sd0);
      push_op(KIND_DELETE, 255, 32'sd0);
      push_op(KIND_DELETE, 2, 32'sd0);
      push_op(KIND_NOP, 255, 32'sh5a5a5a5a);
      push_op(KIND_INSERT, 255, 32'sd3);
      wait_until_drained();

      // capacity lowered below the count
      write_capacity(CAP_W'(2));
      push_op(KIND_INSERT, 1, 32'sd7);
      push_op(KIND_READ, 3, 32'sd0);
      push_op(KIND_DELETE, 1, 32'sd0);
      push_op(KIND_DELETE, 1, 32'sd0);
      push_op(KIND_INSERT, 2, 32'sd9);
      push_op(KIND_INSERT, 3, 32'sd11);
      wait_until_drained();

      // zero capacity acts as one
      write_capacity(CAP_W'(0));
      push_op(KIND_DELETE, 2, 32'sd0);
      push_op(KIND_INSERT, 1, 32'sd13);
      wait_until_drained();

      run_phase(CAP_W'(64), 150, 60, 25);
      run_phase(CAP_W'(64), 100, 25, 60);
      run_phase(CAP_W'(5), 80, 45, 40);
      run_phase(CAP_W'(1), 60, 50, 40);
      run_phase(CAP_W'(127), 120, 60, 25);
      run_phase(CAP_W'(10), 60, 30, 55);
      run_phase(CAP_W'(0), 60, 45, 45);
      run_phase(CAP_W'(100), 130, 45, 40);
      run_phase(CAP_W'(64), 140, 50, 40);

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
design/pidl_pkg.sv
design/pidl_cell.sv
design/positional_insert_delete_list.sv
tb/sv/positional_insert_delete_list_test.sv
